// ===== src/sdf_pkg.sv =====
// ---------------------------------------------------------------------------
// sdf_pkg: shared types and constants of the signed decimal field formatter
// Holds the field descriptor passed from the conversion front end to the
// character emitter, together with character codes and sizing constants.
// ---------------------------------------------------------------------------
package sdf_pkg;

  localparam int MAX_FIELD_DEF   = 64;
  localparam int MAX_FIELD_LIMIT = 64;
  localparam int CNT_W           = $clog2(MAX_FIELD_LIMIT + 1);
  localparam int NUM_DEC         = 10;
  localparam int BCD_W           = 4 * NUM_DEC;
  localparam int ND_W            = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;

  typedef struct packed {
    logic [CNT_W-1:0] pre_cnt;
    logic             has_sign;
    logic [7:0]       sign_char;
    logic [CNT_W-1:0] zero_cnt;
    logic [ND_W-1:0]  num_digits;
    logic [BCD_W-1:0] bcd;
    logic [CNT_W-1:0] post_cnt;
  } sdf_desc_t;

endpackage

// ===== src/sdf_front.sv =====
// ---------------------------------------------------------------------------
// sdf_front: item intake and decimal conversion
// Accepts one item, converts its magnitude to BCD two bits per cycle with
// shift-and-add-three steps, then sizes the padding segments of the field.
// ---------------------------------------------------------------------------
module sdf_front #(
  parameter int MAX_FIELD = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [31:0]       in_value,
  input  logic [6:0]               in_field_width,
  input  logic [5:0]               in_min_digits,
  input  logic                     in_flag_plus,
  input  logic                     in_flag_space,
  input  logic                     in_flag_left,
  input  logic                     in_flag_zero_pad,
  output logic                     push_valid,
  input  logic                     push_ready,
  output sdf_pkg::sdf_desc_t       push_desc
);
  import sdf_pkg::*;

  localparam int STEPS = 16;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_FIELD);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_CALC, F_PUSH} fstate_t;

  fstate_t          state_r;
  logic [3:0]       step_r;
  logic [31:0]      mag_r;
  logic [BCD_W-1:0] bcd_r;
  logic             has_sign_r;
  logic [7:0]       sign_char_r;
  logic [6:0]       width_r;
  logic [5:0]       mind_r;
  logic             left_r;
  logic             zero_r;
  sdf_desc_t        desc_r;
  sdf_desc_t        desc_nxt;
  logic [BCD_W-1:0] bcd_nxt;
  logic [31:0]      mag_in;
  logic             neg_in;
  logic             nz_in;

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
    logic [BCD_W-1:0] a;
    a = b;
    for (int i = 0; i < NUM_DEC; i++) begin
      if (a[4*i +: 4] >= 4'd5) begin
        a[4*i +: 4] = a[4*i +: 4] + 4'd3;
      end
    end
    return {a[BCD_W-2:0], bit_in};
  endfunction

  assign neg_in = in_value[31];
  assign nz_in  = (in_value != 32'sd0);
  assign mag_in = neg_in ? (32'd0 - 32'(in_value)) : 32'(in_value);
  assign bcd_nxt = dabble(dabble(bcd_r, mag_r[31]), mag_r[30]);

  always_comb begin
    logic [ND_W-1:0]  nd;
    logic [CNT_W-1:0] slen;
    logic [CNT_W-1:0] ndig;
    logic [CNT_W-1:0] nd_c;
    logic [CNT_W-1:0] mind_c;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] body;
    logic [CNT_W-1:0] wid;
    logic [CNT_W-1:0] pad;
    nd = ND_W'(1);
    for (int i = 0; i < NUM_DEC; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        nd = ND_W'(i + 1);
      end
    end
    slen   = has_sign_r ? CNT_W'(1) : CNT_W'(0);
    nd_c   = CNT_W'(nd);
    mind_c = CNT_W'(mind_r);
    ndig   = (mind_c > nd_c) ? mind_c : nd_c;
    limit  = MAX_C - slen;
    if (ndig > limit) begin
      ndig = limit;
    end
    body = slen + ndig;
    wid  = (CNT_W'(width_r) > MAX_C) ? MAX_C : CNT_W'(width_r);
    pad  = (wid > body) ? (wid - body) : CNT_W'(0);
    desc_nxt.pre_cnt    = (!left_r && !zero_r) ? pad : CNT_W'(0);
    desc_nxt.has_sign   = has_sign_r;
    desc_nxt.sign_char  = sign_char_r;
    desc_nxt.zero_cnt   = ((!left_r && zero_r) ? pad : CNT_W'(0)) + ndig - nd_c;
    desc_nxt.num_digits = nd;
    desc_nxt.bcd        = bcd_r;
    desc_nxt.post_cnt   = left_r ? pad : CNT_W'(0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= 4'd0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            state_r     <= F_CONV;
            step_r      <= 4'd0;
            mag_r       <= mag_in;
            bcd_r       <= '0;
            has_sign_r  <= neg_in || (nz_in && (in_flag_plus || in_flag_space));
            sign_char_r <= neg_in ? CHAR_MINUS : (in_flag_plus ? CHAR_PLUS : CHAR_SPACE);
            width_r     <= in_field_width;
            mind_r      <= in_min_digits;
            left_r      <= in_flag_left;
            zero_r      <= in_flag_zero_pad;
          end
        end
        F_CONV: begin
          bcd_r  <= bcd_nxt;
          mag_r  <= {mag_r[29:0], 2'b00};
          step_r <= step_r + 4'd1;
          if (step_r == 4'(STEPS - 1)) begin
            state_r <= F_CALC;
          end
        end
        F_CALC: begin
          desc_r  <= desc_nxt;
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_desc  = desc_r;

endmodule

// ===== src/sdf_queue.sv =====
// ---------------------------------------------------------------------------
// sdf_queue: descriptor queue between front end and emitter
// A small register FIFO that lets conversion of one field overlap the
// emission of the previous one.
// ---------------------------------------------------------------------------
module sdf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  sdf_pkg::sdf_desc_t push_desc,
  output logic               pop_valid,
  input  logic               pop_ready,
  output sdf_pkg::sdf_desc_t pop_desc
);
  import sdf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

  sdf_desc_t        slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_Q-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
  endfunction

  assign push_ready = (count_r != CNT_Q'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != CNT_Q'(0));
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_desc   = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_Q'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_Q'(1);
      end
    end
  end

endmodule

// ===== src/sdf_emit.sv =====
// ---------------------------------------------------------------------------
// sdf_emit: character emitter
// Walks the segments of one field descriptor (leading spaces, sign, zeros,
// digits, trailing spaces) and produces one character per cycle into an
// output register while the receiver keeps taking them.
// ---------------------------------------------------------------------------
module sdf_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  sdf_pkg::sdf_desc_t pop_desc,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               out_last_char
);
  import sdf_pkg::*;

  logic             cur_valid_r;
  logic [CNT_W-1:0] pre_r;
  logic             sign_r;
  logic [7:0]       sign_char_r;
  logic [CNT_W-1:0] zero_r;
  logic [ND_W-1:0]  nd_r;
  logic [BCD_W-1:0] bcd_r;
  logic [CNT_W-1:0] post_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;

  logic             emit;
  logic             load;
  logic [7:0]       char_nxt;
  logic             last_nxt;
  logic [CNT_W-1:0] pre_nxt;
  logic             sign_nxt;
  logic [CNT_W-1:0] zero_nxt;
  logic [ND_W-1:0]  nd_nxt;
  logic [CNT_W-1:0] post_nxt;
  logic [3:0]       digit;
  logic [BCD_W-1:0] bcd_sh;
  logic             more_post;
  logic             more_dig;
  logic             more_zero;
  logic             more_sign;

  assign emit = cur_valid_r && (!out_valid_r || out_ready);
  assign load = pop_valid && (!cur_valid_r || (emit && last_nxt));
  assign pop_ready = load;

  assign bcd_sh    = bcd_r >> {nd_r - ND_W'(1), 2'b00};
  assign digit     = bcd_sh[3:0];
  assign more_post = (post_r != '0);
  assign more_dig  = (nd_r != '0) || more_post;
  assign more_zero = (zero_r != '0) || more_dig;
  assign more_sign = sign_r || more_zero;

  always_comb begin
    pre_nxt  = pre_r;
    sign_nxt = sign_r;
    zero_nxt = zero_r;
    nd_nxt   = nd_r;
    post_nxt = post_r;
    char_nxt = CHAR_SPACE;
    last_nxt = 1'b0;
    priority if (pre_r != '0) begin
      pre_nxt  = pre_r - CNT_W'(1);
      last_nxt = (pre_r == CNT_W'(1)) && !more_sign;
    end else if (sign_r) begin
      sign_nxt = 1'b0;
      char_nxt = sign_char_r;
      last_nxt = !more_zero;
    end else if (zero_r != '0) begin
      zero_nxt = zero_r - CNT_W'(1);
      char_nxt = CHAR_ZERO;
      last_nxt = (zero_r == CNT_W'(1)) && !more_dig;
    end else if (nd_r != '0) begin
      nd_nxt   = nd_r - ND_W'(1);
      char_nxt = CHAR_ZERO + {4'd0, digit};
      last_nxt = (nd_r == ND_W'(1)) && !more_post;
    end else begin
      post_nxt = post_r - CNT_W'(1);
      last_nxt = (post_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        out_char_r  <= char_nxt;
        out_last_r  <= last_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        cur_valid_r <= 1'b1;
        pre_r       <= pop_desc.pre_cnt;
        sign_r      <= pop_desc.has_sign;
        sign_char_r <= pop_desc.sign_char;
        zero_r      <= pop_desc.zero_cnt;
        nd_r        <= pop_desc.num_digits;
        bcd_r       <= pop_desc.bcd;
        post_r      <= pop_desc.post_cnt;
      end else if (emit) begin
        cur_valid_r <= !last_nxt;
        pre_r       <= pre_nxt;
        sign_r      <= sign_nxt;
        zero_r      <= zero_nxt;
        nd_r        <= nd_nxt;
        post_r      <= post_nxt;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

endmodule

// ===== src/signed_decimal_field_formatter_core.sv =====
// ---------------------------------------------------------------------------
// signed_decimal_field_formatter_core: printf-style signed decimal field
// Formats one signed 32-bit value per item into an ASCII field, one
// character per result item, with the final character marked.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) takes a value with its field width,
// minimum digit count and flags. The output channel (out_valid/out_ready)
// returns the field's characters in order, out_last_char set on the last.
// An accepted item passes through BCD conversion in the front end (two
// bits per cycle), a sizing step and a queue write before the emitter
// produces its first character.
// Characters then leave at one per cycle while the receiver is ready,
// with no gap between fields when the next descriptor is already queued.
// The front end takes a new item only after pushing the previous one's
// descriptor, while the emitter drains earlier fields through a
// two-entry descriptor queue.
// When the receiver stalls, the current character is held in the output
// register, the queue fills, and in_ready stays low while the front end
// holds a finished field it cannot store. A synchronous reset empties the
// queue and output register and returns the front end to idle.
// ---------------------------------------------------------------------------
module signed_decimal_field_formatter_core #(
  parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_field_width,
  input  logic [5:0]         in_min_digits,
  input  logic               in_flag_plus,
  input  logic               in_flag_space,
  input  logic               in_flag_left,
  input  logic               in_flag_zero_pad,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               out_last_char
);
  import sdf_pkg::*;

  logic      push_valid;
  logic      push_ready;
  sdf_desc_t push_desc;
  logic      pop_valid;
  logic      pop_ready;
  sdf_desc_t pop_desc;

  sdf_front #(
    .MAX_FIELD(MAX_FIELD)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_field_width   (in_field_width),
    .in_min_digits    (in_min_digits),
    .in_flag_plus     (in_flag_plus),
    .in_flag_space    (in_flag_space),
    .in_flag_left     (in_flag_left),
    .in_flag_zero_pad (in_flag_zero_pad),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_desc        (push_desc)
  );

  sdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  sdf_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_desc      (pop_desc),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for signed_decimal_field_formatter_core
// A queue of field requests feeds a valid/ready driver. Each accepted item is
// formatted by a behavioral printf-style "%d" predictor into expected
// characters. A monitor compares each output character and its last mark.
// Both sides idle at random, with one calm stretch, one long receiver
// hold-off and two sender pauses until the block has drained.
// ---------------------------------------------------------------------------
module testbench;

  localparam int FIELD_MAX    = 64;
  localparam int IDLE_PCT     = 22;
  localparam int RANDOM_ITEMS = 350;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int CALM_FROM    = 180;
  localparam int CALM_TO      = 260;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 250000;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [7:0] ASCII_PLUS  = 8'h2b;
  localparam logic [7:0] NO_SIGN     = 8'h00;

  typedef struct {
    logic signed [31:0] value;
    logic [6:0]         field_width;
    logic [5:0]         min_digits;
    logic               plus;
    logic               space;
    logic               left;
    logic               zero_pad;
    logic               wait_drain;
  } field_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_value = '0;
  logic [6:0]         in_field_width = '0;
  logic [5:0]         in_min_digits = '0;
  logic               in_flag_plus = 1'b0;
  logic               in_flag_space = 1'b0;
  logic               in_flag_left = 1'b0;
  logic               in_flag_zero_pad = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_char;
  logic               out_last_char;

  field_req_t  field_reqs[$];
  field_char_t field_chars[$];
  field_req_t  cur_req;

  int items_taken = 0;
  int chars_seen = 0;
  int fields_seen = 0;
  int in_stall_cycles = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int cycles = 0;
  int faults = 0;
  logic calm;

  assign calm = (items_taken >= CALM_FROM) && (items_taken < CALM_TO);

  signed_decimal_field_formatter_core #(
    .MAX_FIELD(FIELD_MAX)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .in_field_width  (in_field_width),
    .in_min_digits   (in_min_digits),
    .in_flag_plus    (in_flag_plus),
    .in_flag_space   (in_flag_space),
    .in_flag_left    (in_flag_left),
    .in_flag_zero_pad(in_flag_zero_pad),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_char   (out_last_char)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void predict_field(input field_req_t r);
    logic [31:0] mag;
    logic [7:0]  digs[10];
    logic [7:0]  text[FIELD_MAX];
    logic [7:0]  sign_c;
    field_char_t fc;
    int nd, slen, ndig, body, width, pad, total, p;
    mag = r.value[31] ? (~r.value + 32'd1) : r.value;
    nd = 0;
    do begin
      digs[nd] = ASCII_ZERO + 8'(mag % 32'd10);
      mag = mag / 32'd10;
      nd++;
    end while (mag != 0);
    sign_c = NO_SIGN;
    if (r.value[31]) begin
      sign_c = ASCII_MINUS;
    end else if (r.value != 0 && r.plus) begin
      sign_c = ASCII_PLUS;
    end else if (r.value != 0 && r.space) begin
      sign_c = ASCII_SPACE;
    end
    slen = (sign_c != NO_SIGN) ? 1 : 0;
    ndig = (int'(r.min_digits) > nd) ? int'(r.min_digits) : nd;
    if (slen + ndig > FIELD_MAX) begin
      ndig = FIELD_MAX - slen;
    end
    body = slen + ndig;
    width = (int'(r.field_width) > FIELD_MAX) ? FIELD_MAX : int'(r.field_width);
    pad = (width > body) ? width - body : 0;
    total = body + pad;
    p = 0;
    if (!r.left && !r.zero_pad) begin
      for (int i = 0; i < pad; i++) begin
        text[p] = ASCII_SPACE;
        p++;
      end
    end
    if (slen != 0) begin
      text[p] = sign_c;
      p++;
    end
    if (!r.left && r.zero_pad) begin
      for (int i = 0; i < pad; i++) begin
        text[p] = ASCII_ZERO;
        p++;
      end
    end
    for (int i = 0; i < ndig - nd; i++) begin
      text[p] = ASCII_ZERO;
      p++;
    end
    for (int i = nd; i > 0; i--) begin
      text[p] = digs[i - 1];
      p++;
    end
    if (r.left) begin
      for (int i = 0; i < pad; i++) begin
        text[p] = ASCII_SPACE;
        p++;
      end
    end
    for (int i = 0; i < total; i++) begin
      fc.ch = text[i];
      fc.last = (i + 1 == total);
      field_chars.push_back(fc);
    end
  endfunction

  function automatic field_req_t make_req(input logic signed [31:0] value,
                                          input int width, input int mind,
                                          input bit plus, input bit space,
                                          input bit left, input bit zero_pad);
    field_req_t r;
    r.value = value;
    r.field_width = 7'(width);
    r.min_digits = 6'(mind);
    r.plus = plus;
    r.space = space;
    r.left = left;
    r.zero_pad = zero_pad;
    r.wait_drain = 1'b0;
    return r;
  endfunction

  function automatic field_req_t random_req();
    field_req_t r;
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1: v = $urandom;
      2: v = $urandom_range(20);
      3: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      4: v = $urandom_range(999999);
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1) == 1) begin
      v = ~v + 32'd1;
    end
    r.value = v;
    r.field_width = ($urandom_range(99) < 8) ? 7'($urandom_range(127))
                                             : 7'($urandom_range(24));
    r.min_digits = ($urandom_range(99) < 8) ? 6'($urandom_range(63))
                                            : 6'($urandom_range(12));
    r.plus = 1'($urandom_range(1));
    r.space = 1'($urandom_range(1));
    r.left = 1'($urandom_range(1));
    r.zero_pad = 1'($urandom_range(1));
    r.wait_drain = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    field_req_t nxt;
    logic present;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      present = in_valid;
      if (in_valid && !in_ready) begin
        in_stall_cycles <= in_stall_cycles + 1;
      end
      if (in_valid && in_ready) begin
        predict_field(cur_req);
        items_taken <= items_taken + 1;
        present = 1'b0;
      end
      if (!present && field_reqs.size() != 0 &&
          (calm || $urandom_range(99) >= IDLE_PCT) &&
          !(field_reqs[0].wait_drain && field_chars.size() != 0)) begin
        nxt = field_reqs.pop_front();
        cur_req = nxt;
        in_value <= nxt.value;
        in_field_width <= nxt.field_width;
        in_min_digits <= nxt.min_digits;
        in_flag_plus <= nxt.plus;
        in_flag_space <= nxt.space;
        in_flag_left <= nxt.left;
        in_flag_zero_pad <= nxt.zero_pad;
        present = 1'b1;
      end
      in_valid <= present;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_taken == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    field_char_t fc;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        chars_seen <= chars_seen + 1;
        if (out_last_char) begin
          fields_seen <= fields_seen + 1;
        end
        if (field_chars.size() == 0) begin
          if (faults < 10) begin
            $display("unexpected character %h (last %b) with nothing pending",
                     out_char, out_last_char);
          end
          faults++;
        end else begin
          fc = field_chars.pop_front();
          if (out_char !== fc.ch || out_last_char !== fc.last) begin
            if (faults < 10) begin
              $display("mismatch at character %0d: expected %h last %b, got %h last %b",
                       chars_seen, fc.ch, fc.last, out_char, out_last_char);
            end
            faults++;
          end
        end
      end
      out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    field_req_t r;
    field_reqs.push_back(make_req(32'sd0, 0, 0, 0, 0, 0, 0));
    field_reqs.push_back(make_req(32'sd0, 0, 0, 1, 1, 0, 0));
    field_reqs.push_back(make_req(-32'sd2147483648, 0, 0, 1, 1, 0, 0));
    field_reqs.push_back(make_req(32'sd2147483647, 0, 0, 1, 0, 0, 0));
    field_reqs.push_back(make_req(32'sd5, 0, 0, 0, 1, 0, 0));
    field_reqs.push_back(make_req(32'sd42, 0, 0, 1, 1, 0, 0));
    field_reqs.push_back(make_req(-32'sd7, 10, 0, 0, 0, 0, 1));
    field_reqs.push_back(make_req(-32'sd7, 10, 0, 0, 0, 1, 0));
    field_reqs.push_back(make_req(-32'sd7, 10, 0, 0, 0, 1, 1));
    field_reqs.push_back(make_req(32'sd123, 10, 0, 0, 0, 0, 0));
    field_reqs.push_back(make_req(32'sd123, 0, 63, 1, 0, 0, 0));
    field_reqs.push_back(make_req(-32'sd1, 0, 63, 0, 0, 0, 0));
    field_reqs.push_back(make_req(32'sd1, 127, 63, 0, 0, 0, 0));
    field_reqs.push_back(make_req(32'sd99, 127, 0, 0, 1, 0, 1));
    field_reqs.push_back(make_req(-32'sd2147483648, 127, 5, 0, 0, 1, 0));
    field_reqs.push_back(make_req(32'sd12345, 3, 2, 0, 0, 0, 1));
    field_reqs.push_back(make_req(32'sd7, 8, 5, 1, 0, 0, 1));
    field_reqs.push_back(make_req(32'sd0, 5, 0, 1, 0, 0, 0));
    field_reqs.push_back(make_req(32'sd0, 64, 63, 0, 1, 1, 0));
    field_reqs.push_back(make_req(32'sh5555_5555, 65, 12, 0, 1, 0, 0));
    field_reqs.push_back(make_req(32'shaaaa_aaaa, 64, 11, 0, 0, 0, 1));
    field_reqs.push_back(make_req(-32'sd2147483647, 12, 11, 1, 1, 1, 1));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = random_req();
      r.wait_drain = (i == 0) || (i == RANDOM_ITEMS - 60);
      field_reqs.push_back(r);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (field_reqs.size() != 0 || in_valid || field_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (field_chars.size() != 0) begin
      if (faults < 10) begin
        $display("%0d expected characters never arrived", field_chars.size());
      end
      faults++;
    end
    $display("Formatted %0d fields into %0d characters in %0d cycles.",
             fields_seen, chars_seen, cycles);
    $display("Input was held back for %0d cycles; %0d failures recorded.",
             in_stall_cycles, faults);
    if (faults == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
